>>> rtl/core/adb_key_event_matrix_macros.svh
// Assertion helpers for the key event matrix.
// Each macro expects clk and rst_n in scope.
`ifndef ADB_KEY_EVENT_MATRIX_MACROS_SVH
`define ADB_KEY_EVENT_MATRIX_MACROS_SVH

// Same-cycle implication.
`define ADBKEM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adbkem assertion failed");

// Next-cycle implication.
`define ADBKEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adbkem assertion failed");

`endif

>>> rtl/core/adbkem_pkg.sv
package adbkem_pkg;

  localparam int unsigned NumRows = 16;
  localparam int unsigned NumCols = 8;

  typedef logic [NumRows-1:0][NumCols-1:0] key_bitmap_t;
  typedef logic [1:0] status_t;

  // Result status codes
  localparam status_t STATUS_NO_KEYS = 2'd0;
  localparam status_t STATUS_ERROR   = 2'd1;
  localparam status_t STATUS_APPLIED = 2'd2;

  // Marker byte: error lead-in in the first event, "no event" in the second
  localparam logic [7:0] EVENT_NONE = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_IDX_GHOST_EN = 1'b0;

  // Stage-two word handed to the report stage
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] error_byte;
  } upd_info_t;

  // Apply one key event: bit 7 releases, else presses row ev[6:3], column ev[2:0]
  function automatic key_bitmap_t apply_event(key_bitmap_t map, logic [7:0] ev);
    key_bitmap_t res;
    res = map;
    res[ev[6:3]][ev[2:0]] = ~ev[7];
    return res;
  endfunction

endpackage

>>> rtl/core/adbkem_if.sv
// Input channel: one report word
interface adbkem_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] report_word;

  modport source (output valid, output report_word, input ready);
  modport sink   (input valid, input report_word, output ready);
endinterface

// Result channel: status plus bitmap summary
interface adbkem_out_if;
  logic                  valid;
  logic                  ready;
  adbkem_pkg::status_t   status;
  logic [7:0]            error_byte;
  logic [7:0]            pressed_count;
  logic                  ghost_flag;
  logic [63:0]           rows_lower;
  logic [63:0]           rows_upper;

  modport source (output valid, output status, output error_byte, output pressed_count,
                  output ghost_flag, output rows_lower, output rows_upper, input ready);
  modport sink   (input valid, input status, input error_byte, input pressed_count,
                  input ghost_flag, input rows_lower, input rows_upper, output ready);
endinterface

>>> rtl/core/adb_key_event_matrix.sv
// Keyboard report decoder holding a 16 x 8 key bitmap.
// in_ch takes one 16-bit report word per handshake; the high byte is the
// first key event, the low byte the second (bit 7 release, bits 6:3 row,
// bits 2:0 column). out_ch returns one result word per report: status,
// error byte, pressed-key count, ghost flag and the whole bitmap.
// Path: a word passes the input register, the bitmap update and the result
// register in that order before its result shows on out_ch.
// Throughput: one word per cycle while out_ch.ready holds; the bitmap update
// feeds back on itself and the count and ghost compare sit in the stage after.
// A stalled receiver holds the result register; the two earlier stages
// keep taking words until they are full, then in_ch.ready drops.
// Reset (rst_n low at a clock edge) clears the bitmap, all valid flags and
// ghost_check_enable. The APB-style port at byte address 0 holds
// ghost_check_enable; write it only while no word is in flight.
`include "adb_key_event_matrix_macros.svh"

module adb_key_event_matrix (
  input  logic         clk,
  input  logic         rst_n,
  adbkem_in_if.sink    in_ch,
  adbkem_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                    ghost_en_r;
  logic                    cfg_wr;
  logic                    rpt_ready;
  logic                    upd_fire;
  adbkem_pkg::upd_info_t   upd_info;
  adbkem_pkg::key_bitmap_t bitmap;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == adbkem_pkg::CFG_IDX_GHOST_EN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ghost_en_r <= 1'b0;
    end else if (cfg_wr) begin
      ghost_en_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == adbkem_pkg::CFG_IDX_GHOST_EN) ? {31'd0, ghost_en_r} : 32'd0;

  adbkem_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rpt_ready (rpt_ready),
    .upd_info  (upd_info),
    .bitmap    (bitmap),
    .upd_fire  (upd_fire)
  );

  adbkem_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_info  (upd_info),
    .bitmap    (bitmap),
    .ghost_en  (ghost_en_r),
    .rpt_ready (rpt_ready),
    .out_ch    (out_ch)
  );

  // Checks
  `ADBKEM_ASSERT_NEXT(a_bitmap_hold, !upd_fire, $stable(bitmap))
  `ADBKEM_ASSERT_IMPL(a_err_byte_zero, out_ch.valid && out_ch.status != adbkem_pkg::STATUS_ERROR, out_ch.error_byte == 8'd0)
  `ADBKEM_ASSERT_IMPL(a_ghost_gated, out_ch.valid && out_ch.ghost_flag, ghost_en_r)
  `ADBKEM_ASSERT_IMPL(a_ready_when_empty, !out_ch.valid, in_ch.ready)

endmodule

>>> rtl/core/adbkem_update.sv
module adbkem_update (
  input  logic                    clk,
  input  logic                    rst_n,
  adbkem_in_if.sink               in_ch,
  input  logic                    rpt_ready,
  output adbkem_pkg::upd_info_t   upd_info,
  output adbkem_pkg::key_bitmap_t bitmap,
  output logic                    upd_fire
);

  logic                    s1_valid_r, s1_valid_nxt;
  logic [15:0]             s1_word_r;
  logic                    s1_ready;
  logic                    s2_ready;
  adbkem_pkg::upd_info_t   s2_r, s2_nxt;
  adbkem_pkg::key_bitmap_t bitmap_r, bitmap_nxt;
  logic [7:0]              first_ev;
  logic [7:0]              second_ev;
  adbkem_pkg::key_bitmap_t map_first;

  // Handshake between the two stages
  assign s2_ready    = !s2_r.valid || rpt_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign upd_fire    = s1_valid_r && s2_ready;

  assign first_ev  = s1_word_r[15:8];
  assign second_ev = s1_word_r[7:0];
  assign map_first = adbkem_pkg::apply_event(bitmap_r, first_ev);

  // Decode the word and apply its events in order
  always_comb begin
    bitmap_nxt          = bitmap_r;
    s2_nxt              = s2_r;
    s1_valid_nxt        = s1_valid_r;
    if (s2_ready) begin
      s2_nxt.valid = 1'b0;
    end
    if (upd_fire) begin
      s2_nxt.valid      = 1'b1;
      s2_nxt.error_byte = 8'd0;
      if (s1_word_r == 16'd0) begin
        s2_nxt.status = adbkem_pkg::STATUS_NO_KEYS;
      end else if (first_ev == adbkem_pkg::EVENT_NONE &&
                   second_ev != adbkem_pkg::EVENT_NONE) begin
        s2_nxt.status     = adbkem_pkg::STATUS_ERROR;
        s2_nxt.error_byte = second_ev;
      end else begin
        s2_nxt.status = adbkem_pkg::STATUS_APPLIED;
        if (second_ev != adbkem_pkg::EVENT_NONE) begin
          bitmap_nxt = adbkem_pkg::apply_event(map_first, second_ev);
        end else begin
          bitmap_nxt = map_first;
        end
      end
    end
    if (s1_ready) begin
      s1_valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_r.valid <= 1'b0;
      bitmap_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_r.valid <= s2_nxt.valid;
      bitmap_r   <= bitmap_nxt;
    end
    s2_r.status     <= s2_nxt.status;
    s2_r.error_byte <= s2_nxt.error_byte;
    // Capture the word when accepted
    if (s1_ready && in_ch.valid) begin
      s1_word_r <= in_ch.report_word;
    end
  end

  assign upd_info = s2_r;
  assign bitmap   = bitmap_r;

endmodule

>>> rtl/core/adbkem_report.sv
module adbkem_report (
  input  logic                    clk,
  input  logic                    rst_n,
  input  adbkem_pkg::upd_info_t   upd_info,
  input  adbkem_pkg::key_bitmap_t bitmap,
  input  logic                    ghost_en,
  output logic                    rpt_ready,
  adbkem_out_if.source            out_ch
);

  logic                valid_r;
  adbkem_pkg::status_t status_r;
  logic [7:0]          error_r;
  logic [7:0]          count_r;
  logic                ghost_r;
  logic [127:0]        rows_r;

  logic [7:0]          count_nxt;
  logic                ghost_nxt;
  logic [15:0]         multi_key;
  logic [15:0]         row_ghost;
  logic                load;

  assign rpt_ready = !valid_r || out_ch.ready;
  assign load      = rpt_ready && upd_info.valid;

  // Count pressed keys, summing the rows in a chain of adders
  always_comb begin
    count_nxt = 8'd0;
    for (int r = 0; r < adbkem_pkg::NumRows; r++) begin
      count_nxt = count_nxt + 8'($countones(bitmap[r]));
    end
  end

  // Flag rows holding two or more keys that another row fully covers, if ghost_en
  always_comb begin
    for (int r = 0; r < adbkem_pkg::NumRows; r++) begin
      multi_key[r] = |(bitmap[r] & (bitmap[r] - 8'd1));
      row_ghost[r] = 1'b0;
      for (int o = 0; o < adbkem_pkg::NumRows; o++) begin
        if (o != r && (bitmap[o] & bitmap[r]) == bitmap[r]) begin
          row_ghost[r] = multi_key[r];
        end
      end
    end
    ghost_nxt = ghost_en && (|row_ghost);
  end

  // Result register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rpt_ready) begin
      valid_r <= upd_info.valid;
    end
    if (load) begin
      status_r <= upd_info.status;
      error_r  <= upd_info.error_byte;
      count_r  <= count_nxt;
      ghost_r  <= ghost_nxt;
      rows_r   <= bitmap;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.error_byte    = error_r;
  assign out_ch.pressed_count = count_r;
  assign out_ch.ghost_flag    = ghost_r;
  assign out_ch.rows_lower    = rows_r[63:0];
  assign out_ch.rows_upper    = rows_r[127:64];

endmodule
